@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WAM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wam assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define WAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wam assertion failed");

`endif

@@ rtl/wam_pkg.sv @@
// Shared types and constants of the wildcard alternation matcher.
package wam_pkg;

  // Input action codes.
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_NAME   = 2'd1;
  localparam logic [1:0] ACT_END    = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  // Special pattern bytes.
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  // Stream payload widths.
  localparam int IN_W  = 8;
  localparam int OUT_W = 16;

  // Kind of sweep over the pattern positions.
  typedef enum logic [1:0] {
    MODE_START,
    MODE_ADVANCE,
    MODE_COUNT
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  latch_char;
    logic  append;
    logic  clear;
    logic  start;
    mode_t mode;
    logic  load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pass_done;
  } sts_t;

endpackage

@@ rtl/wam_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module wam_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/wam_datapath.sv @@
// Datapath: pattern store, active position store and the position sweep.
module wam_datapath #(
  parameter int PATTERN_LEN = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_char,
  input  wam_pkg::cmd_t cmd,
  output wam_pkg::sts_t sts,
  output logic [7:0]    match_count,
  output logic          pattern_overflow
);

  localparam int LW    = $clog2(PATTERN_LEN + 1);
  localparam int PW    = $clog2(PATTERN_LEN);
  localparam int CW    = $clog2(PATTERN_LEN + 2);
  localparam int CNT_W = (CW > 8) ? CW : 8;

  logic [LW-1:0]    pat_len;
  logic             ovf;
  logic [7:0]       char_q;
  wam_pkg::mode_t   mode_q;
  logic             rd_on;
  logic [LW-1:0]    rp;
  logic             pv;
  logic [LW-1:0]    pp;
  logic             here_q;
  logic [7:0]       prev_pc;
  logic             prev_act;
  logic             prev_val;
  logic [CNT_W-1:0] count;

  logic [7:0]       pat_rdata;
  logic             act_rdata;
  logic             pat_we;
  logic [PW-1:0]    pat_raddr;
  logic             act_we;
  logic             first;
  logic             star_h;
  logic             bar_h;
  logic             prev_star;
  logic             prev_bar;
  logic             prev_lit;
  logic             val;
  logic             hit;
  logic [CNT_W-1:0] count_sum;
  logic             room;

  // Pattern bytes, written at the current length.
  assign room      = pat_len < LW'(PATTERN_LEN);
  assign pat_we    = cmd.append && room;
  assign pat_raddr = (rp < pat_len) ? rp[PW-1:0] : '0;

  wam_ram #(
    .WIDTH (8),
    .DEPTH (PATTERN_LEN)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_len[PW-1:0]),
    .wdata (in_char),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  // One active bit per position, rewritten by each start or advance sweep.
  assign act_we = pv && (mode_q != wam_pkg::MODE_COUNT);

  wam_ram #(
    .WIDTH (1),
    .DEPTH (PATTERN_LEN + 1)
  ) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (pp),
    .wdata (val),
    .raddr (rp),
    .rdata (act_rdata)
  );

  // Classify the position being processed and the one before it.
  always_comb begin
    first     = (pp == '0);
    star_h    = here_q && (pat_rdata == wam_pkg::CH_STAR);
    bar_h     = here_q && (pat_rdata == wam_pkg::CH_BAR);
    prev_star = !first && (prev_pc == wam_pkg::CH_STAR);
    prev_bar  = !first && (prev_pc == wam_pkg::CH_BAR);
    prev_lit  = !first && !prev_star && !prev_bar &&
                ((prev_pc == wam_pkg::CH_QUEST) || (prev_pc == char_q));
  end

  // New active bit of this position; star closure carries from the previous one.
  always_comb begin
    case (mode_q)
      wam_pkg::MODE_START:   val = first || prev_bar || (prev_val && prev_star);
      wam_pkg::MODE_ADVANCE: val = (act_rdata && star_h) || (prev_act && prev_lit) ||
                                   (prev_val && prev_star);
      wam_pkg::MODE_COUNT:   val = act_rdata;
      default:               val = 1'b0;
    endcase
  end

  // An active position at the end of an alternative is one match.
  assign hit       = pv && val && (!here_q || bar_h);
  assign count_sum = count + CNT_W'(hit);

  assign sts.pass_done = pv && (pp == pat_len);

  // Control state: pattern length, overflow flag and the sweep pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len <= '0;
      ovf     <= 1'b0;
      rd_on   <= 1'b0;
      pv      <= 1'b0;
    end else begin
      if (cmd.append) begin
        if (room) begin
          pat_len <= pat_len + LW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.clear) begin
        pat_len <= '0;
        ovf     <= 1'b0;
      end
      pv <= rd_on;
      if (rd_on) begin
        if (rp == pat_len) begin
          rd_on <= 1'b0;
        end else begin
          rp <= rp + LW'(1);
        end
      end
      if (cmd.start) begin
        rd_on <= 1'b1;
        rp    <= '0;
      end
    end
  end

  // Payload registers of the sweep and the result.
  always_ff @(posedge clk) begin
    if (rd_on) begin
      pp     <= rp;
      here_q <= rp < pat_len;
    end
    if (pv) begin
      prev_pc  <= pat_rdata;
      prev_act <= act_rdata;
      prev_val <= val;
    end
    if (cmd.start) begin
      mode_q <= cmd.mode;
      count  <= '0;
    end else begin
      count <= count_sum;
    end
    if (cmd.latch_char) begin
      char_q <= in_char;
    end
    if (cmd.load_out) begin
      match_count      <= count_sum[7:0];
      pattern_overflow <= ovf;
    end
  end

endmodule

@@ rtl/wam_ctrl.sv @@
// Controller: accepts items, sequences the sweeps and holds the result valid.
module wam_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  input  logic [1:0]    s_action,
  output logic          s_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output wam_pkg::cmd_t cmd,
  input  wam_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_WAIT
  } state_t;

  state_t state;
  logic   in_prog;
  logic   then_adv;
  logic   emit;
  logic   accept;
  logic   out_free;

  assign s_ready  = (state == ST_IDLE);
  assign accept   = s_ready && s_valid;
  assign out_free = !out_valid || out_ready;

  // Command decode.
  always_comb begin
    cmd = '0;
    cmd.mode = wam_pkg::MODE_START;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.latch_char = 1'b1;
          unique case (s_action)
            wam_pkg::ACT_APPEND: cmd.append = 1'b1;
            wam_pkg::ACT_CLEAR:  cmd.clear = 1'b1;
            wam_pkg::ACT_NAME: begin
              cmd.start = 1'b1;
              cmd.mode  = in_prog ? wam_pkg::MODE_ADVANCE : wam_pkg::MODE_START;
            end
            wam_pkg::ACT_END: begin
              cmd.start = 1'b1;
              cmd.mode  = in_prog ? wam_pkg::MODE_COUNT : wam_pkg::MODE_START;
            end
            default: cmd.latch_char = 1'b1;
          endcase
        end
      end
      ST_PASS: begin
        if (sts.pass_done) begin
          if (then_adv) begin
            cmd.start = 1'b1;
            cmd.mode  = wam_pkg::MODE_ADVANCE;
          end else if (emit && out_free) begin
            cmd.load_out = 1'b1;
          end
        end
      end
      ST_WAIT: begin
        cmd.load_out = out_free;
      end
      default: cmd = '0;
    endcase
  end

  // State, name progress and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_prog   <= 1'b0;
      then_adv  <= 1'b0;
      emit      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (s_action)
              wam_pkg::ACT_NAME: begin
                then_adv <= !in_prog;
                emit     <= 1'b0;
                in_prog  <= 1'b1;
                state    <= ST_PASS;
              end
              wam_pkg::ACT_END: begin
                then_adv <= 1'b0;
                emit     <= 1'b1;
                in_prog  <= 1'b0;
                state    <= ST_PASS;
              end
              default: in_prog <= 1'b0;
            endcase
          end
        end
        ST_PASS: begin
          if (sts.pass_done) begin
            if (then_adv) begin
              then_adv <= 1'b0;
            end else if (emit && !out_free) begin
              state <= ST_WAIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_WAIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/wildcard_alternation_matcher.sv @@
// Pattern appends and clears need no sweep and leave the input ready; with L stored
// pattern bytes, a filename byte runs one sweep, or a start then an advance sweep when
// it starts a new name. An end of name shows its result and frees the input in the
// same cycle; if an earlier result is still held, it waits until that one is taken.
// Reset clears the pattern length, overflow flag and name progress; the pattern store
// is not cleared and active positions are rebuilt at the start of every name.
module wildcard_alternation_matcher #(
  parameter int PATTERN_LEN = 128
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // Fields from bit 0: action[1:0].
  input  logic [1:0]               s_axis_tuser,
  // Fields from bit 0: char_value[7:0].
  input  logic [wam_pkg::IN_W-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // Fields from bit 0: match_count[7:0], pattern_overflow[8], zero pad.
  output logic [wam_pkg::OUT_W-1:0] m_axis_tdata
);

  wam_pkg::cmd_t cmd;
  wam_pkg::sts_t sts;
  logic [7:0]    match_count;
  logic          pattern_overflow;

  // Sequencing of items and sweeps.
  wam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_action  (s_axis_tuser),
    .s_ready   (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Stores and the position sweep.
  wam_datapath #(
    .PATTERN_LEN (PATTERN_LEN)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .in_char          (s_axis_tdata),
    .cmd              (cmd),
    .sts              (sts),
    .match_count      (match_count),
    .pattern_overflow (pattern_overflow)
  );

  // Result packing.
  assign m_axis_tdata = {{(wam_pkg::OUT_W - 9){1'b0}}, pattern_overflow, match_count};

endmodule

@@ rtl/wam_checker.sv @@
// Port-level checker for the wildcard alternation matcher, with its bind.
`include "assert_macros.svh"

module wam_port_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [1:0]                s_axis_tuser,
  input logic [wam_pkg::IN_W-1:0]  s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [wam_pkg::OUT_W-1:0] m_axis_tdata
);

  logic in_acc;
  logic acc_short;
  logic acc_name;

  // Accepted items by kind.
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign acc_short = in_acc && ((s_axis_tuser == wam_pkg::ACT_APPEND) ||
                                (s_axis_tuser == wam_pkg::ACT_CLEAR));
  assign acc_name  = in_acc && (s_axis_tuser == wam_pkg::ACT_NAME);

  // A held result stays valid and unchanged.
  `WAM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `WAM_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // Pattern edits leave the input ready in the next cycle; a filename byte starts a sweep.
  `WAM_ASSERT_NEXT(a_edit_one_cycle, acc_short, s_axis_tready)
  `WAM_ASSERT_NEXT(a_name_sweeps, acc_name, !s_axis_tready)

endmodule

bind wildcard_alternation_matcher wam_port_checker u_wam_checker (.*);

@@ test/wam_checker.sv @@
// Checker for the wildcard alternation matcher: predicts match results and compares them.
module wam_checker #(
  parameter int PATTERN_LEN = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  // Fields from bit 0: action[1:0].
  input  logic [1:0]                s_axis_tuser,
  // Fields from bit 0: char_value[7:0].
  input  logic [wam_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // Fields from bit 0: match_count[7:0], pattern_overflow[8], zero pad.
  input  logic [wam_pkg::OUT_W-1:0] m_axis_tdata,
  output int                        errors,
  output int                        pending,
  output int                        results_seen,
  output int                        max_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] count;
    logic       overflow;
  } match_result_t;

  // Shadow copy of the block state.
  logic [7:0]           pat_mem [PATTERN_LEN];
  int                   pat_len;
  logic [PATTERN_LEN:0] live_pos;
  logic                 name_open;
  logic                 dropped;

  match_result_t expected_matches [$];
  match_result_t want;

  // A '*' on a live position also makes the following position live.
  function automatic logic [PATTERN_LEN:0] close_stars(input logic [PATTERN_LEN:0] v);
    for (int p = 0; p < pat_len; p++) begin
      if (v[p] && pat_mem[p] == wam_pkg::CH_STAR) v[p+1] = 1'b1;
    end
    return v;
  endfunction

  // Every alternative begins at position 0 or just after a separator.
  function automatic logic [PATTERN_LEN:0] start_positions();
    logic [PATTERN_LEN:0] v;
    v    = '0;
    v[0] = 1'b1;
    for (int p = 0; p < pat_len; p++) begin
      if (pat_mem[p] == wam_pkg::CH_BAR) v[p+1] = 1'b1;
    end
    return close_stars(v);
  endfunction

  // Consume one name byte across all live positions.
  function automatic logic [PATTERN_LEN:0] next_positions(input logic [7:0] c);
    logic [PATTERN_LEN:0] v;
    v = '0;
    for (int p = 0; p < pat_len; p++) begin
      if (live_pos[p] && pat_mem[p] != wam_pkg::CH_BAR) begin
        if (pat_mem[p] == wam_pkg::CH_STAR) v[p] = 1'b1;
        else if (pat_mem[p] == wam_pkg::CH_QUEST || pat_mem[p] == c) v[p+1] = 1'b1;
      end
    end
    return close_stars(v);
  endfunction

  // A live position at the end of an alternative is one matching alternative.
  function automatic logic [7:0] count_matches();
    logic [7:0] cnt;
    cnt = '0;
    for (int p = 0; p <= pat_len; p++) begin
      if (live_pos[p] && (p >= pat_len || pat_mem[p] == wam_pkg::CH_BAR)) cnt++;
    end
    return cnt;
  endfunction

  // Apply one accepted item to the shadow state.
  task automatic predict_matches(input logic [1:0] act, input logic [7:0] ch);
    case (act)
      wam_pkg::ACT_APPEND: begin
        if (pat_len < PATTERN_LEN) begin
          pat_mem[pat_len] = ch;
          pat_len++;
        end else begin
          dropped = 1'b1;
        end
        name_open = 1'b0;
      end
      wam_pkg::ACT_NAME: begin
        if (!name_open) begin
          live_pos  = start_positions();
          name_open = 1'b1;
        end
        live_pos = next_positions(ch);
      end
      wam_pkg::ACT_END: begin
        if (!name_open) live_pos = start_positions();
        expected_matches.push_back('{count: count_matches(), overflow: dropped});
        name_open = 1'b0;
      end
      default: begin
        pat_len   = 0;
        dropped   = 1'b0;
        name_open = 1'b0;
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      pat_len   = 0;
      live_pos  = '0;
      name_open = 1'b0;
      dropped   = 1'b0;
      expected_matches.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_matches(s_axis_tuser, s_axis_tdata[7:0]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tdata[7:0] > max_count) max_count = m_axis_tdata[7:0];
        if (expected_matches.size() == 0) begin
          report_mismatch($sformatf("result 0x%0h with no pending expectation",
                                    m_axis_tdata));
        end else begin
          want = expected_matches.pop_front();
          if (m_axis_tdata[7:0] !== want.count) begin
            report_mismatch($sformatf("match_count expected %0d, got %0d",
                                      want.count, m_axis_tdata[7:0]));
          end
          if (m_axis_tdata[8] !== want.overflow) begin
            report_mismatch($sformatf("pattern_overflow expected %0b, got %0b",
                                      want.overflow, m_axis_tdata[8]));
          end
        end
      end
    end
    pending = expected_matches.size();
  end

endmodule

@@ test/wildcard_alternation_matcher_tb.sv @@
// Top-level testbench of the wildcard alternation matcher: stimulus and verdict.
module wildcard_alternation_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PLEN        = 128;
  localparam int PHASE_ITEMS = 350;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 2 * PLEN + 20;

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [1:0]                s_tuser  = '0;
  logic [wam_pkg::IN_W-1:0]  s_tdata  = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [wam_pkg::OUT_W-1:0] m_tdata;

  int errors;
  int pending;
  int results_seen;
  int max_count;
  int tx_idle     = 7;
  int rx_idle     = 54;
  int items_sent  = 0;
  int full_loads  = 0;
  int unsigned cycles = 0;
  int phase_base;

  // Bytes currently held in the pattern store, used to build matching names.
  logic [7:0] pat_copy [$];

  always #10 clk = ~clk;

  wildcard_alternation_matcher #(.PATTERN_LEN(PLEN)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tuser (s_tuser),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata)
  );

  wam_checker #(.PATTERN_LEN(PLEN)) checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tuser (s_tuser),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .max_count    (max_count)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver backpressure.
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= rx_idle);
  end

  // Offer one item, with random idle cycles first, and wait until it is taken.
  task automatic send_item(input logic [1:0] act, input logic [7:0] ch);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid = 1'b0;
      s_tuser  = 2'($urandom);
      s_tdata  = wam_pkg::IN_W'($urandom);
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (act == wam_pkg::ACT_APPEND && pat_copy.size() < PLEN) pat_copy.push_back(ch);
    else if (act == wam_pkg::ACT_CLEAR) pat_copy.delete();
  endtask

  // Pattern bytes lean on a small alphabet and the wildcard characters.
  function automatic logic [7:0] pat_char();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'h61 + 8'($urandom_range(2));
    if (r < 60) return wam_pkg::CH_STAR;
    if (r < 72) return wam_pkg::CH_QUEST;
    if (r < 84) return wam_pkg::CH_BAR;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] name_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'h61 + 8'($urandom_range(2));
    if (r < 80) return wam_pkg::CH_STAR;
    if (r < 85) return wam_pkg::CH_QUEST;
    if (r < 90) return wam_pkg::CH_BAR;
    return 8'($urandom_range(255));
  endfunction

  task automatic load_pattern(input int n);
    repeat (n) send_item(wam_pkg::ACT_APPEND, pat_char());
  endtask

  // Send one name and its end marker; a matching name follows one alternative.
  task automatic send_name(input bit want_match);
    logic [7:0] nm [$];
    int         starts [$];
    int         p;
    if (want_match) begin
      starts.push_back(0);
      for (int i = 0; i < pat_copy.size(); i++) begin
        if (pat_copy[i] == wam_pkg::CH_BAR) starts.push_back(i + 1);
      end
      p = starts[$urandom_range(starts.size() - 1)];
      while (p < pat_copy.size() && pat_copy[p] != wam_pkg::CH_BAR) begin
        if (pat_copy[p] == wam_pkg::CH_STAR) begin
          repeat ($urandom_range(3)) nm.push_back(name_char());
        end else if (pat_copy[p] == wam_pkg::CH_QUEST) begin
          nm.push_back(name_char());
        end else begin
          nm.push_back(pat_copy[p]);
        end
        p++;
      end
      if (nm.size() > 0 && $urandom_range(99) < 15) begin
        nm[$urandom_range(nm.size() - 1)] = name_char();
      end
    end else begin
      repeat ($urandom_range(6)) nm.push_back(name_char());
    end
    foreach (nm[i]) send_item(wam_pkg::ACT_NAME, nm[i]);
    send_item(wam_pkg::ACT_END, 8'($urandom));
  endtask

  // Fill the store to capacity, possibly past it, then match short names.
  task automatic fill_store(input bit all_bars, input int extra);
    send_item(wam_pkg::ACT_CLEAR, 8'($urandom));
    repeat (PLEN + extra) send_item(wam_pkg::ACT_APPEND, all_bars ? wam_pkg::CH_BAR : pat_char());
    full_loads++;
    send_item(wam_pkg::ACT_END, 8'($urandom));
    send_name(1'b0);
  endtask

  // Hand-picked cases starting from the reset state.
  task automatic directed_checks();
    // Empty pattern with an empty name, then with a one-byte name.
    send_item(wam_pkg::ACT_END, 8'hFF);
    send_item(wam_pkg::ACT_NAME, 8'h61);
    send_item(wam_pkg::ACT_END, 8'h00);
    // Pattern a*|?|* exercises every kind of pattern byte.
    send_item(wam_pkg::ACT_APPEND, 8'h61);
    send_item(wam_pkg::ACT_APPEND, wam_pkg::CH_STAR);
    send_item(wam_pkg::ACT_APPEND, wam_pkg::CH_BAR);
    send_item(wam_pkg::ACT_APPEND, wam_pkg::CH_QUEST);
    send_item(wam_pkg::ACT_APPEND, wam_pkg::CH_BAR);
    send_item(wam_pkg::ACT_APPEND, wam_pkg::CH_STAR);
    send_item(wam_pkg::ACT_NAME, 8'h61);
    send_item(wam_pkg::ACT_NAME, 8'h62);
    send_item(wam_pkg::ACT_END, 8'h00);
    // Extreme byte values in the name.
    send_item(wam_pkg::ACT_NAME, 8'hFF);
    send_item(wam_pkg::ACT_NAME, 8'h00);
    send_item(wam_pkg::ACT_END, 8'hFF);
    // Empty name against star-only and literal alternatives.
    send_item(wam_pkg::ACT_END, 8'h00);
    send_item(wam_pkg::ACT_NAME, 8'h71);
    send_item(wam_pkg::ACT_END, 8'hFF);
    // A pattern append in the middle of a name abandons it.
    send_item(wam_pkg::ACT_NAME, 8'h61);
    send_item(wam_pkg::ACT_APPEND, 8'h62);
    send_item(wam_pkg::ACT_NAME, 8'h78);
    send_item(wam_pkg::ACT_NAME, 8'h62);
    send_item(wam_pkg::ACT_END, 8'h00);
    // Clearing in the middle of a name leaves an empty pattern.
    send_item(wam_pkg::ACT_NAME, 8'h7A);
    send_item(wam_pkg::ACT_CLEAR, 8'hFF);
    send_item(wam_pkg::ACT_END, 8'hFF);
  endtask

  // Mostly well-formed load-and-match sequences, with noise and broken ones mixed in.
  task automatic random_sequence();
    int r;
    r = $urandom_range(99);
    if (r < 3) begin
      fill_store(1'($urandom_range(1)), $urandom_range(3));
    end else if (r < 13) begin
      repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
    end else if (r < 22) begin
      if ($urandom_range(1)) send_item(wam_pkg::ACT_CLEAR, 8'($urandom));
      load_pattern($urandom_range(1, 8));
      repeat ($urandom_range(1, 3)) send_item(wam_pkg::ACT_NAME, name_char());
      if ($urandom_range(1)) send_item(wam_pkg::ACT_APPEND, pat_char());
      else send_item(wam_pkg::ACT_CLEAR, 8'($urandom));
      send_name(1'($urandom_range(1)));
    end else begin
      if ($urandom_range(99) < 80) send_item(wam_pkg::ACT_CLEAR, 8'($urandom));
      load_pattern($urandom_range(12));
      repeat ($urandom_range(1, 4)) send_name($urandom_range(99) < 60);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Three idle mixes; each phase drains before the next one starts.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle = 7;
          rx_idle = 54;
        end
        1: begin
          tx_idle = 54;
          rx_idle = 7;
        end
        default: begin
          tx_idle = 0;
          rx_idle = 0;
        end
      endcase
      phase_base = items_sent;
      if (phase == 0) directed_checks();
      fill_store(phase == 0, (phase == 0) ? 2 : $urandom_range(3));
      while (items_sent - phase_base < PHASE_ITEMS) random_sequence();
      s_tvalid = 1'b0;
      while (pending != 0) @(negedge clk);
      @(negedge clk);
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Sent %0d items and checked %0d match results; store filled to capacity %0d times.",
             items_sent, results_seen, full_loads);
    $display("Largest match count seen was %0d, across three backpressure mixes.", max_count);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
